[rtl/batch_signal_store_table_macros.svh]
// Assertion helpers shared by the block's RTL
`ifndef BATCH_SIGNAL_STORE_TABLE_MACROS_SVH
`define BATCH_SIGNAL_STORE_TABLE_MACROS_SVH

// Check a condition at every clock edge outside reset
`define BSST_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("bsst check failed");

// Check that a trigger is followed by a condition in the next cycle
`define BSST_ASSERT_NEXT(lbl, clk, rst_n, trig, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (expr)) \
        else $error("bsst sequence check failed");

`endif

[rtl/bsst_pkg.sv]
package bsst_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int BATCH_MAX_DEF   = 16;
    localparam int CODE_BITS       = 16;

    // request codes
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_BATCH  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_TOOLONG  = 2'd3;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [31:0]          word;
        logic [63:0]          time_ms;
        logic [31:0]          session;
        logic [31:0]          sequence_no;
    } t_entry;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [31:0]          word;
    } t_pend;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] word;
        logic [63:0] time_ms;
        logic [31:0] session;
        logic [31:0] sequence_no;
        logic [5:0]  count;
        logic [4:0]  stored;
    } t_result;

endpackage

[rtl/bsst_if.sv]
interface bsst_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] signal_code;
    logic [31:0] signal_word;
    logic        last_in_batch;
    logic        clear_first;
    logic [63:0] batch_time_ms;
    logic [31:0] batch_session;
    logic [31:0] batch_sequence;

    modport source (output valid, req_type, signal_code, signal_word, last_in_batch,
                    clear_first, batch_time_ms, batch_session, batch_sequence,
                    input ready);
    modport sink (input valid, req_type, signal_code, signal_word, last_in_batch,
                  clear_first, batch_time_ms, batch_session, batch_sequence,
                  output ready);
endinterface

interface bsst_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] found_word;
    logic [63:0] found_time_ms;
    logic [31:0] found_session;
    logic [31:0] found_sequence;
    logic [5:0]  occupied_count;
    logic [4:0]  batch_signals_stored;

    modport source (output valid, status, found_word, found_time_ms, found_session,
                    found_sequence, occupied_count, batch_signals_stored,
                    input ready);
    modport sink (input valid, status, found_word, found_time_ms, found_session,
                  found_sequence, occupied_count, batch_signals_stored,
                  output ready);
endinterface

[rtl/bsst_entry_mem.sv]
module bsst_entry_mem #(
    parameter int DEPTH = bsst_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  bsst_pkg::t_entry    i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output bsst_pkg::t_entry    o_rdata
);

    bsst_pkg::t_entry r_mem [DEPTH];
    bsst_pkg::t_entry r_rdata;

    // write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bsst_pend_mem.sv]
module bsst_pend_mem #(
    parameter int DEPTH = bsst_pkg::BATCH_MAX_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  bsst_pkg::t_pend   i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output bsst_pkg::t_pend   o_rdata
);

    bsst_pkg::t_pend r_mem [DEPTH];
    bsst_pkg::t_pend r_rdata;

    // buffer batch signals, read back one per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/batch_signal_store_table.sv]
// Keyed signal table with all-or-nothing batch stores.
// i_req carries one request per transaction: clear table, one batch signal,
// or lookup by code. o_rsp returns at most one result per request through
// an output register, so a new request is taken while a result waits.
// Steps per request:
//   batch signal that is not last: buffered, no result.
//   clear: table emptied, result through the done state.
//   lookup: sequential scan of the entry memory.
//   last batch signal: room check, one scan per signal (none with
//   clear_first), then store, one scan per signal plus a free-entry
//   scan per new code.
// Requests are taken only when the engine is idle.
// Reset clears the valid bits, the entry count and the pending batch at
// once; no clearing pass is needed. When the receiver stalls, the result
// waits in the output register; the engine finishes the next request and
// then holds until the register frees.
`include "batch_signal_store_table_macros.svh"

module batch_signal_store_table #(
    parameter int TABLE_DEPTH = bsst_pkg::TABLE_DEPTH_DEF,
    parameter int BATCH_MAX   = bsst_pkg::BATCH_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsst_req_if.sink    i_req,
    bsst_rsp_if.source  o_rsp
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int UW  = $clog2(TABLE_DEPTH + 1);
    localparam int PW  = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
    localparam int PLW = $clog2(BATCH_MAX + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREAD = 7'b0000010,
        S_PLOAD = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_FREE  = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        PH_LOOKUP = 2'd0,
        PH_CHECK  = 2'd1,
        PH_STORE  = 2'd2
    } t_phase;

    t_state                    r_state;
    t_phase                    r_phase;
    logic [TABLE_DEPTH-1:0]    r_valid;
    logic [UW-1:0]             r_used;
    logic [PLW-1:0]            r_plen;
    logic                      r_ovf;
    logic [PW-1:0]             r_pidx;
    logic [PLW-1:0]            r_need;
    logic [AW-1:0]             r_scan_addr;
    logic                      r_chk;
    logic                      r_chk_v;
    logic                      r_chk_last;
    logic [AW-1:0]             r_chk_idx;
    logic [AW-1:0]             r_slot;
    logic                      r_new;
    logic [bsst_pkg::CODE_BITS-1:0] r_code;
    logic [31:0]               r_word;
    logic [63:0]               r_time;
    logic [31:0]               r_sess;
    logic [31:0]               r_seq;
    bsst_pkg::t_result         r_res;
    bsst_pkg::t_result         r_out;
    logic                      r_out_valid;

    bsst_pkg::t_entry          mem_q;
    bsst_pkg::t_entry          mem_wdata;
    bsst_pkg::t_pend           pend_q;
    bsst_pkg::t_pend           pend_wdata;
    logic                      accept;
    logic                      pend_full;
    logic                      pend_we;
    logic [PLW-1:0]            plen_new;
    logic                      ovf_new;
    logic                      hit;
    logic                      miss;
    logic                      last_p;
    logic [PLW-1:0]            need_new;
    logic                      room_ok;
    logic [UW-1:0]             used_inc;

    assign accept     = i_req.valid && i_req.ready;
    assign pend_full  = (r_plen == PLW'(BATCH_MAX));
    assign pend_we    = accept && (i_req.req_type == bsst_pkg::REQ_BATCH) && !pend_full;
    assign plen_new   = pend_full ? r_plen : r_plen + PLW'(1);
    assign ovf_new    = r_ovf || pend_full;
    assign pend_wdata = '{code: i_req.signal_code[bsst_pkg::CODE_BITS-1:0],
                          word: i_req.signal_word};
    assign hit        = r_chk && r_chk_v && (mem_q.code == r_code);
    assign miss       = r_chk && r_chk_last && !hit;
    assign last_p     = ((PLW'(r_pidx) + PLW'(1)) == r_plen);
    assign need_new   = r_need + PLW'(miss);
    assign room_ok    = (32'(need_new) <= (32'(TABLE_DEPTH) - 32'(r_used)));
    assign used_inc   = r_used + UW'(r_new);
    assign mem_wdata  = '{code: r_code, word: r_word, time_ms: r_time,
                          session: r_sess, sequence_no: r_seq};

    bsst_entry_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_entry_mem (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (r_slot),
        .i_wdata (mem_wdata),
        .i_raddr (r_scan_addr),
        .o_rdata (mem_q)
    );

    bsst_pend_mem #(.DEPTH(BATCH_MAX), .AW(PW)) u_pend_mem (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (r_plen[PW-1:0]),
        .i_wdata (pend_wdata),
        .i_raddr (r_pidx),
        .o_rdata (pend_q)
    );

    // sequence requests through scans of the entry memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_LOOKUP;
            r_valid     <= '0;
            r_used      <= '0;
            r_plen      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once the receiver takes it
            if (o_rsp.ready && r_out_valid && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_req.req_type)
                            bsst_pkg::REQ_CLEAR: begin
                                r_valid <= '0;
                                r_used  <= '0;
                                r_plen  <= '0;
                                r_ovf   <= 1'b0;
                                r_res   <= '{status: bsst_pkg::ST_OK, default: '0};
                                r_state <= S_DONE;
                            end
                            bsst_pkg::REQ_LOOKUP: begin
                                r_res       <= '{status: bsst_pkg::ST_OK,
                                                 count: 6'(r_used), default: '0};
                                r_code      <= i_req.signal_code[bsst_pkg::CODE_BITS-1:0];
                                r_phase     <= PH_LOOKUP;
                                r_scan_addr <= '0;
                                r_chk       <= 1'b0;
                                r_state     <= S_SCAN;
                            end
                            bsst_pkg::REQ_BATCH: begin
                                if (!i_req.last_in_batch) begin
                                    r_plen <= plen_new;
                                    r_ovf  <= ovf_new;
                                end else begin
                                    r_time <= i_req.batch_time_ms;
                                    r_sess <= i_req.batch_session;
                                    r_seq  <= i_req.batch_sequence;
                                    r_pidx <= '0;
                                    r_need <= '0;
                                    if (ovf_new) begin
                                        r_res   <= '{status: bsst_pkg::ST_TOOLONG,
                                                     count: 6'(r_used), default: '0};
                                        r_plen  <= '0;
                                        r_ovf   <= 1'b0;
                                        r_state <= S_DONE;
                                    end else if (i_req.clear_first) begin
                                        if (32'(plen_new) <= 32'(TABLE_DEPTH)) begin
                                            r_res   <= '{status: bsst_pkg::ST_OK,
                                                         count: 6'(r_used), default: '0};
                                            r_plen  <= plen_new;
                                            r_valid <= '0;
                                            r_used  <= '0;
                                            r_phase <= PH_STORE;
                                            r_state <= S_PREAD;
                                        end else begin
                                            r_res   <= '{status: bsst_pkg::ST_FULL,
                                                         count: 6'(r_used), default: '0};
                                            r_plen  <= '0;
                                            r_state <= S_DONE;
                                        end
                                    end else begin
                                        r_res   <= '{status: bsst_pkg::ST_OK,
                                                     count: 6'(r_used), default: '0};
                                        r_plen  <= plen_new;
                                        r_phase <= PH_CHECK;
                                        r_state <= S_PREAD;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PREAD: begin
                    r_state <= S_PLOAD;
                end
                S_PLOAD: begin
                    r_code      <= pend_q.code;
                    r_word      <= pend_q.word;
                    r_scan_addr <= '0;
                    r_chk       <= 1'b0;
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    if (hit || miss) begin
                        r_chk <= 1'b0;
                        case (r_phase)
                            PH_LOOKUP: begin
                                if (hit) begin
                                    r_res <= '{status: bsst_pkg::ST_OK,
                                               word: mem_q.word,
                                               time_ms: mem_q.time_ms,
                                               session: mem_q.session,
                                               sequence_no: mem_q.sequence_no,
                                               count: r_res.count,
                                               stored: '0};
                                end else begin
                                    r_res.status <= bsst_pkg::ST_NOTFOUND;
                                end
                                r_state <= S_DONE;
                            end
                            PH_CHECK: begin
                                r_need <= need_new;
                                if (last_p) begin
                                    if (room_ok) begin
                                        r_pidx  <= '0;
                                        r_phase <= PH_STORE;
                                        r_state <= S_PREAD;
                                    end else begin
                                        r_res.status <= bsst_pkg::ST_FULL;
                                        r_plen       <= '0;
                                        r_state      <= S_DONE;
                                    end
                                end else begin
                                    r_pidx  <= r_pidx + PW'(1);
                                    r_state <= S_PREAD;
                                end
                            end
                            default: begin
                                if (hit) begin
                                    r_slot  <= r_chk_idx;
                                    r_new   <= 1'b0;
                                    r_state <= S_WRITE;
                                end else begin
                                    r_scan_addr <= '0;
                                    r_state     <= S_FREE;
                                end
                            end
                        endcase
                    end else begin
                        // issue the next entry read
                        r_chk       <= 1'b1;
                        r_chk_idx   <= r_scan_addr;
                        r_chk_v     <= r_valid[r_scan_addr];
                        r_chk_last  <= (r_scan_addr == AW'(TABLE_DEPTH - 1));
                        r_scan_addr <= r_scan_addr + AW'(1);
                    end
                end
                S_FREE: begin
                    if (!r_valid[r_scan_addr]) begin
                        r_slot  <= r_scan_addr;
                        r_new   <= 1'b1;
                        r_state <= S_WRITE;
                    end else if (r_scan_addr == AW'(TABLE_DEPTH - 1)) begin
                        // no free entry: skip this signal
                        if (last_p) begin
                            r_res   <= '{status: bsst_pkg::ST_OK, count: 6'(r_used),
                                         stored: 5'(r_plen), default: '0};
                            r_plen  <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_pidx  <= r_pidx + PW'(1);
                            r_state <= S_PREAD;
                        end
                    end else begin
                        r_scan_addr <= r_scan_addr + AW'(1);
                    end
                end
                S_WRITE: begin
                    r_valid[r_slot] <= 1'b1;
                    r_used          <= used_inc;
                    if (last_p) begin
                        r_res   <= '{status: bsst_pkg::ST_OK, count: 6'(used_inc),
                                     stored: 5'(r_plen), default: '0};
                        r_plen  <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_pidx  <= r_pidx + PW'(1);
                        r_state <= S_PREAD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready                = (r_state == S_IDLE);
    assign o_rsp.valid                = r_out_valid;
    assign o_rsp.status               = r_out.status;
    assign o_rsp.found_word           = r_out.word;
    assign o_rsp.found_time_ms        = r_out.time_ms;
    assign o_rsp.found_session        = r_out.session;
    assign o_rsp.found_sequence       = r_out.sequence_no;
    assign o_rsp.occupied_count       = r_out.count;
    assign o_rsp.batch_signals_stored = r_out.stored;

    `BSST_ASSERT_ALWAYS(a_used_bound, i_clk, i_rst_n, 32'(r_used) <= 32'(TABLE_DEPTH))
    `BSST_ASSERT_ALWAYS(a_plen_bound, i_clk, i_rst_n, 32'(r_plen) <= 32'(BATCH_MAX))
    `BSST_ASSERT_ALWAYS(a_stored_ok, i_clk, i_rst_n,
        !r_out_valid || (r_out.stored == '0) || (r_out.status == bsst_pkg::ST_OK))
    `BSST_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n,
        accept && (i_req.req_type == bsst_pkg::REQ_CLEAR), (r_used == '0) && (r_plen == '0))

endmodule
